/* hw/rtl/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, register indexes and pixel arithmetic for the Bayer demosaic.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ORDER  = 2'd2;

	localparam int MAX_HEIGHT = 4096;

	typedef logic [7:0] pix_t;

	// window [column k][row r]: r 0 up, 1 current, 2 down; k 2 is the newest column
	typedef logic [2:0][2:0][7:0] win_t;

	typedef struct packed {
		logic left;
		logic right;
		logic odd;
	} pos_t;

	typedef struct packed {
		logic grgr;
		logic first;
		logic last;
	} rowctl_t;

	typedef struct packed {
		logic    emit_a;
		logic    emit_b;
		pos_t    pos_a;
		pos_t    pos_b;
		rowctl_t rc;
	} stage_ctl_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic row_end;
		logic frame_end;
	} result_t;

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + 9'd1;
		return s[8:1];
	endfunction

	// (2t+o)/3 as a multiply by 683/2048, exact below 2048
	function automatic pix_t third(input pix_t t, input pix_t o);
		logic [9:0]  x;
		logic [19:0] m;
		x = {1'b0, t, 1'b0} + {2'b00, o};
		m = x * 10'd683;
		return m[18:11];
	endfunction

	function automatic pix_t vert(input win_t w, input logic [1:0] k,
		input logic first, input logic last);
		pix_t v;
		if (first) begin
			v = w[k][2];
		end else if (last) begin
			v = w[k][0];
		end else begin
			v = avg2(w[k][0], w[k][2]);
		end
		return v;
	endfunction

	function automatic result_t make_pixel(input win_t w, input logic [1:0] k,
		input pos_t pos, input rowctl_t rc);
		logic [1:0] kl;
		logic [1:0] kr;
		pix_t c, cl, cr, v, vl, vr, h, x, pl;
		result_t o;
		kl = k - 2'd1;
		kr = (k < 2'd2) ? k + 2'd1 : 2'd2;
		c  = w[k][1];
		cl = w[kl][1];
		cr = w[kr][1];
		v  = vert(w, k, rc.first, rc.last);
		vl = vert(w, kl, rc.first, rc.last);
		vr = vert(w, kr, rc.first, rc.last);
		h  = avg2(cl, cr);
		x  = avg2(vl, vr);
		pl = (rc.first || rc.last) ? third(h, v) : avg2(h, v);
		o = '0;
		if (!rc.grgr) begin
			if (pos.left) begin
				o.blue = c; o.green = third(v, cr); o.red = vr;
			end else if (pos.right) begin
				o.blue = cl; o.green = c; o.red = v;
			end else if (pos.odd) begin
				o.blue = h; o.green = c; o.red = v;
			end else begin
				o.blue = c; o.green = pl; o.red = x;
			end
		end else begin
			if (pos.left) begin
				o.blue = v; o.green = c; o.red = cr;
			end else if (pos.right) begin
				o.blue = vl; o.green = third(v, cl); o.red = c;
			end else if (pos.odd) begin
				o.blue = x; o.green = pl; o.red = c;
			end else begin
				o.blue = v; o.green = c; o.red = h;
			end
		end
		return o;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bbd_line_store.sv */
// ----------------------------------------------------------------------------
// bbd_line_store
// Two line buffers in one memory: each entry holds the row above and the
// current row of one column; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_line_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [15:0]        rdata,   // [7:0] current row, [15:8] row above
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bbd_out_queue.sv */
// ----------------------------------------------------------------------------
// bbd_out_queue
// Four-entry result queue taking up to two pixels per cycle, one out.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_a,
	input  wire bbd_pkg::result_t data_a,
	input  wire logic             push_b,
	input  wire bbd_pkg::result_t data_b,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output bbd_pkg::result_t      out_data
);
	import bbd_pkg::*;

	result_t    ent_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wp_b;

	assign out_valid = (count_q != 3'd0);
	assign out_data  = ent_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= 3'd2);
	assign wp_b      = push_a ? wp_q + 2'd1 : wp_q;

	always_ff @(posedge clk) begin
		if (push_a) begin
			ent_q[wp_q] <= data_a;
		end
		if (push_b) begin
			ent_q[wp_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + {1'b0, push_a} + {1'b0, push_b};
			rp_q    <= rp_q + {1'b0, pop};
			count_q <= count_q + {2'b00, push_a} + {2'b00, push_b} - {2'b00, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4) else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a || push_b) |-> count_q <= 3'd2) else $error("push without room");
	a_b_after_a: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a && push_b) |=> count_q >= 3'd1) else $error("double push lost");

endmodule

`default_nettype wire

/* hw/rtl/bayer_bilinear_demosaic_bgr_core.sv */
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_bgr_core
// Bilinear Bayer demosaic, 8-bit raw in, BGR out, one row and column behind.
//
//  channel  dir  fields
//  s_axis   in   tdata: raw_pixel; tuser: command
//  m_axis   out  tdata: blue, green, red; tlast: row_end; tuser: frame_end
//  cfg      in   index 0 image_width, 1 image_height, 2 first_row_order
//
// One raw item per cycle while the queue has room. Stages: line store read,
// window update, result queue. The last item of a row yields two
// pixels; the four-entry result queue absorbs them. The line store takes one
// read and one write per cycle. Reset is asynchronous and needs no clearing
// pass. A stalled m_axis holds the whole pipeline through s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_bilinear_demosaic_bgr_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] raw_pixel
	input  wire logic        s_axis_tuser,   // [0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
	output logic             m_axis_tlast,
	output logic             m_axis_tuser,   // [0] frame_end
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	import bbd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	logic [12:0]   width_q, height_q;
	logic          order_q;
	logic [WW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic [CW-1:0] col_q;
	logic [12:0]   row_q;
	logic          grgr_q;

	logic          en, acc, grgr_now, row_end, has_out, last;
	logic [WW-1:0] col_ext;
	stage_ctl_t    ctl_now, ctl_s1, ctl_s2;
	logic          s1_valid, s2_valid;
	logic [CW-1:0] col_s1;
	pix_t          sample_s1;
	logic [15:0]   rdata;
	logic          mem_we;
	win_t          win_q;
	result_t       pix_a, pix_b, q_data;
	logic          push_a, push_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			order_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_ORDER:  order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < 13'd4) begin
			w_eff = WW'(4);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < 13'd2) begin
			h_eff = 13'd2;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && en;

	always_comb begin
		col_ext  = WW'(col_q);
		grgr_now = (row_q == 13'd0 && col_q == '0) ? order_q : grgr_q;
		row_end  = (col_ext + WW'(1)) >= w_eff;
		has_out  = (row_q != 13'd0);
		last     = (row_q >= h_eff);
		ctl_now.emit_a      = has_out && (col_q != '0);
		ctl_now.emit_b      = has_out && row_end;
		ctl_now.pos_a.left  = (col_q == CW'(1));
		ctl_now.pos_a.right = (col_ext >= w_eff);
		ctl_now.pos_a.odd   = ~col_q[0];
		ctl_now.pos_b.left  = (col_q == '0);
		ctl_now.pos_b.right = 1'b1;
		ctl_now.pos_b.odd   = col_q[0];
		ctl_now.rc.grgr     = grgr_now;
		ctl_now.rc.first    = (row_q == 13'd1);
		ctl_now.rc.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			grgr_q <= 1'b0;
		end else if (acc) begin
			grgr_q <= grgr_now ^ (has_out && row_end);
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_q >= h_eff) ? 13'd0 : row_q + 13'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// pipeline advances only while the result queue can take two pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else if (en) begin
			s1_valid <= acc;
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1    <= col_q;
			sample_s1 <= s_axis_tuser ? 8'd0 : s_axis_tdata;
			ctl_s1    <= ctl_now;
		end
		if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign mem_we = en && s1_valid;

	bbd_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line (
		.clk   (clk),
		.re    (acc),
		.raddr (col_q),
		.rdata (rdata),
		.we    (mem_we),
		.waddr (col_s1),
		.wdata ({rdata[7:0], sample_s1})
	);

	// shift the 3x3 window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (mem_we) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= rdata[15:8];
			win_q[2][1] <= rdata[7:0];
			win_q[2][2] <= sample_s1;
		end
	end

	always_comb begin
		pix_a           = make_pixel(win_q, 2'd1, ctl_s2.pos_a, ctl_s2.rc);
		pix_b           = make_pixel(win_q, 2'd2, ctl_s2.pos_b, ctl_s2.rc);
		pix_b.row_end   = 1'b1;
		pix_b.frame_end = ctl_s2.rc.last;
	end

	assign push_a = en && s2_valid && ctl_s2.emit_a;
	assign push_b = en && s2_valid && ctl_s2.emit_b;

	bbd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (push_a),
		.data_a    (pix_a),
		.push_b    (push_b),
		.data_b    (pix_b),
		.room      (en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (q_data)
	);

	assign m_axis_tdata = {q_data.red, q_data.green, q_data.blue};
	assign m_axis_tlast = q_data.row_end;
	assign m_axis_tuser = q_data.frame_end;

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mem_we) |-> (col_q != col_s1)) else $error("line store read/write collide");
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && row_end) |=> (col_q == '0)) else $error("column did not wrap");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !en) |=> (s1_valid && $stable(col_s1))) else $error("stage 1 lost on stall");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic core testbench
// Streams whole frames of raw Bayer samples through the core under several
// sizes and row orders, predicts every BGR pixel in step with the input and
// checks each output transfer against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module testbench;
	import bbd_pkg::*;

	typedef struct {
		bit         flush;
		logic [7:0] sample;
	} raw_item_t;

	typedef struct {
		logic [7:0] b, g, r;
		bit         row_end, frame_end;
	} bgr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] raw_pixel
	logic        s_axis_tuser = 1'b0;  // [0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [7:0] blue, [15:8] green, [23:16] red
	logic        m_axis_tlast;
	logic        m_axis_tuser;         // [0] frame_end
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [12:0] cfg_data = '0;

	bayer_bilinear_demosaic_bgr_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [12:0] width_reg = 13'd640, height_reg = 13'd480;
	bit          order_reg = 1'b0;
	logic [7:0]  above_ln [4096];
	logic [7:0]  middle_ln [4096];
	logic [7:0]  win [9];
	int unsigned col_cnt = 0, row_cnt = 0;
	bit          grgr = 1'b0;

	raw_item_t feed_q[$];
	bgr_t      bgr_q[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        src_gap = 0, snk_gap = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned mean2(int unsigned a, int unsigned b);
		return (a + b + 1) >> 1;
	endfunction

	function automatic int unsigned third_of(int unsigned t, int unsigned o);
		return (2 * t + o) / 3;
	endfunction

	function automatic int unsigned vert_at(int k, bit top, bit bottom);
		if (top) return win[6 + k];
		if (bottom) return win[k];
		return mean2(win[k], win[6 + k]);
	endfunction

	function automatic bgr_t bgr_pixel(int k, int unsigned p, int unsigned w, bit top,
		bit bottom);
		int          kl, kr;
		int unsigned c, cl, cr, v, vl, vr, hz, xa, pa;
		bgr_t        o;
		kl = k - 1;
		kr = (k < 2) ? k + 1 : 2;
		c  = win[3 + k];
		cl = win[3 + kl];
		cr = win[3 + kr];
		v  = vert_at(k, top, bottom);
		vl = vert_at(kl, top, bottom);
		vr = vert_at(kr, top, bottom);
		hz = mean2(cl, cr);
		xa = mean2(vl, vr);
		pa = (top || bottom) ? third_of(hz, v) : mean2(hz, v);
		if (!grgr) begin
			if (p == 0) begin
				o.b = c; o.g = third_of(v, cr); o.r = vr;
			end else if (p + 1 >= w) begin
				o.b = cl; o.g = c; o.r = v;
			end else if (p[0]) begin
				o.b = hz; o.g = c; o.r = v;
			end else begin
				o.b = c; o.g = pa; o.r = xa;
			end
		end else begin
			if (p == 0) begin
				o.b = v; o.g = c; o.r = cr;
			end else if (p + 1 >= w) begin
				o.b = vl; o.g = third_of(v, cl); o.r = c;
			end else if (p[0]) begin
				o.b = xa; o.g = pa; o.r = c;
			end else begin
				o.b = v; o.g = c; o.r = hz;
			end
		end
		o.row_end = 1'b0;
		o.frame_end = 1'b0;
		return o;
	endfunction

	function automatic int unsigned eff_width();
		return (width_reg < 4) ? 4 : (width_reg > 4096) ? 4096 : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 2) ? 2 : (height_reg > 4096) ? 4096 : height_reg;
	endfunction

	task automatic demosaic_step(bit flush, logic [7:0] raw);
		int unsigned w, h, col, orow;
		logic [7:0]  s;
		bit          last_col, top, bottom;
		bgr_t        px;
		w = eff_width();
		h = eff_height();
		s = flush ? 8'd0 : raw;
		col = (col_cnt >= 4096) ? 4095 : col_cnt;
		if (row_cnt == 0 && col == 0) grgr = order_reg;
		for (int r = 0; r < 3; r++) begin
			win[3*r] = win[3*r + 1];
			win[3*r + 1] = win[3*r + 2];
		end
		win[2] = above_ln[col];
		win[5] = middle_ln[col];
		win[8] = s;
		above_ln[col] = middle_ln[col];
		middle_ln[col] = s;
		last_col = (col + 1 >= w);
		if (row_cnt >= 1) begin
			orow = row_cnt - 1;
			top = (orow == 0);
			bottom = (orow + 1 >= h);
			if (col >= 1) bgr_q.push_back(bgr_pixel(1, col - 1, w, top, bottom));
			if (last_col) begin
				px = bgr_pixel(2, col, w, top, bottom);
				px.row_end = 1'b1;
				px.frame_end = bottom;
				bgr_q.push_back(px);
				grgr = !grgr;
			end
		end
		if (last_col) begin
			col_cnt = 0;
			row_cnt = (row_cnt >= h) ? 0 : row_cnt + 1;
		end else begin
			col_cnt = col + 1;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	// raw sample driver
	always @(posedge clk) begin
		raw_item_t it;
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (src_gap > 0 || feed_q.size() == 0) begin
				if (src_gap > 0) src_gap <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else begin
				it = feed_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= it.flush;
				s_axis_tdata <= it.sample;
				src_gap <= pick_gap();
			end
		end
	end

	// result side: stall, predict on accepted input, check accepted output
	always @(posedge clk) begin
		bgr_t want;
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) snk_gap <= pick_gap();
			end
		end
		if (s_axis_tvalid && s_axis_tready) demosaic_step(s_axis_tuser, s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) begin
			if (bgr_q.size() == 0) begin
				errors++;
				$display("unexpected pixel at %0t", $time);
			end else begin
				want = bgr_q.pop_front();
				if (m_axis_tdata[7:0] !== want.b)
					report_mismatch("blue", m_axis_tdata[7:0], want.b);
				if (m_axis_tdata[15:8] !== want.g)
					report_mismatch("green", m_axis_tdata[15:8], want.g);
				if (m_axis_tdata[23:16] !== want.r)
					report_mismatch("red", m_axis_tdata[23:16], want.r);
				if (m_axis_tlast !== want.row_end)
					report_mismatch("row_end", m_axis_tlast, want.row_end);
				if (m_axis_tuser !== want.frame_end)
					report_mismatch("frame_end", m_axis_tuser, want.frame_end);
			end
		end
	end

	// watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_drained();
		wait (feed_q.size() == 0 && !s_axis_tvalid && bgr_q.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:  width_reg = val;
			REG_HEIGHT: height_reg = val;
			REG_ORDER:  order_reg = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup(logic [12:0] w, logic [12:0] h, bit ord);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_ORDER, ord);
	endtask

	// one full frame of random content plus its flush row
	task automatic random_frame(bit pause_mid);
		int unsigned w, h;
		raw_item_t   it;
		w = eff_width();
		h = eff_height();
		for (int r = 0; r <= h; r++) begin
			if (pause_mid && r == h / 2 + 1) begin
				wait (feed_q.size() == 0 && !s_axis_tvalid);
				wait (bgr_q.size() == 0);
			end
			for (int c = 0; c < w; c++) begin
				if (r < h) it.flush = ($urandom_range(0, 19) == 0);
				else it.flush = ($urandom_range(0, 9) != 0);
				it.sample = $urandom_range(0, 255);
				feed_q.push_back(it);
			end
		end
		wait_drained();
	endtask

	task automatic push_item(bit fl, logic [7:0] s);
		raw_item_t it;
		it.flush = fl;
		it.sample = s;
		feed_q.push_back(it);
	endtask

	initial begin
		int count;
		int unsigned w, h;
		for (int i = 0; i < 9; i++) win[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 4x2 BGBG, extremes, flush inside image, raw inside flush row
		setup(13'd4, 13'd2, 1'b0);
		push_item(0, 8'd0);   push_item(0, 8'd255); push_item(0, 8'd0);   push_item(0, 8'd255);
		push_item(0, 8'd255); push_item(1, 8'd77);  push_item(0, 8'd255); push_item(0, 8'd0);
		push_item(1, 8'd0);   push_item(0, 8'd200); push_item(1, 8'd255); push_item(1, 8'd0);
		wait_drained();
		// directed: odd width 5, GRGR first
		setup(13'd5, 13'd2, 1'b1);
		for (int i = 0; i < 10; i++) push_item(0, i[0] ? 8'd255 : 8'd1);
		for (int i = 0; i < 5; i++) push_item(1, 8'd128);
		wait_drained();

		// saturated sizes
		setup(13'd0, 13'd1, 1'b0);
		random_frame(1'b1);
		setup(13'd3, 13'd0, 1'b1);
		random_frame(1'b0);

		// mostly small random frames
		count = 0;
		while (count < 400) begin
			w = $urandom_range(4, 12);
			h = $urandom_range(2, 6);
			setup(w, h, $urandom_range(0, 1));
			random_frame($urandom_range(0, 7) == 0);
			count += w * (h + 1);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
